@@ sv/hmpg_pkg.sv @@
// types, constants and microcode table for the henon map point generator
package hmpg_pkg;

	localparam int unsigned COORD_FRAC_BITS_DEF = 28;
	localparam int unsigned SCALE_FRAC_BITS     = 16;

	localparam int unsigned COORD_W  = 32;
	localparam int unsigned SCALE_W  = 28;
	localparam int unsigned PIX_W    = 12;
	localparam int unsigned COUNT_W  = 24;
	localparam int unsigned OPER_W   = 33;
	localparam int unsigned PROD_W   = 2 * OPER_W;
	localparam int unsigned SUM_W    = PROD_W + 2;
	localparam int unsigned STEP_W   = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// register addresses (word index)
	localparam logic [2:0] REG_COEF_A        = 3'd0;
	localparam logic [2:0] REG_COEF_B        = 3'd1;
	localparam logic [2:0] REG_SCREEN_SCALE  = 3'd2;
	localparam logic [2:0] REG_SCREEN_CENTER = 3'd3;
	localparam logic [2:0] REG_SCREEN_LIMIT  = 3'd4;

	localparam logic [COORD_W-1:0] COEF_A_RST        = 32'd375809638;
	localparam logic [COORD_W-1:0] COEF_B_RST        = 32'd80530637;
	localparam logic [SCALE_W-1:0] SCREEN_SCALE_RST  = 28'd15291733;
	localparam logic [PIX_W-1:0]   SCREEN_CENTER_RST = 12'd350;
	localparam logic [PIX_W-1:0]   SCREEN_LIMIT_RST  = 12'd700;

	typedef enum logic [1:0] {OPA_X, OPA_A, OPA_B, OPA_SCALE} opa_t;
	typedef enum logic [1:0] {OPB_X, OPB_SQ, OPB_NX, OPB_Y} opb_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} jmp_t;

	typedef struct packed {
		opa_t              opa;
		opb_t              opb;
		logic              p_en;
		logic              sq_en;
		logic              nx_en;
		logic              map_en;
		logic              px_en;
		logic              out_en;
		jmp_t              jmp;
		logic [STEP_W-1:0] next;
	} ctrl_t;

	// microcode: one control word per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '{opa: OPA_X, opb: OPB_X, p_en: 1'b0, sq_en: 1'b0, nx_en: 1'b0,
			map_en: 1'b0, px_en: 1'b0, out_en: 1'b0, jmp: JMP_NEXT, next: '0};
		case (step)
			3'd0: begin
				c.jmp  = JMP_WAIT_IN;
				c.next = 3'd1;
			end
			3'd1: begin
				c.p_en = 1'b1;
				c.next = 3'd2;
			end
			3'd2: begin
				c.sq_en = 1'b1;
				c.next  = 3'd3;
			end
			3'd3: begin
				c.opa  = OPA_A;
				c.opb  = OPB_SQ;
				c.p_en = 1'b1;
				c.next = 3'd4;
			end
			3'd4: begin
				c.opa   = OPA_B;
				c.opb   = OPB_X;
				c.p_en  = 1'b1;
				c.nx_en = 1'b1;
				c.next  = 3'd5;
			end
			3'd5: begin
				c.opa    = OPA_SCALE;
				c.opb    = OPB_NX;
				c.p_en   = 1'b1;
				c.map_en = 1'b1;
				c.next   = 3'd6;
			end
			3'd6: begin
				c.opa   = OPA_SCALE;
				c.opb   = OPB_Y;
				c.p_en  = 1'b1;
				c.px_en = 1'b1;
				c.next  = 3'd7;
			end
			3'd7: begin
				c.out_en = 1'b1;
				c.jmp    = JMP_WAIT_OUT;
				c.next   = 3'd0;
			end
			default: begin
				c.next = 3'd0;
			end
		endcase
		return c;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
		lo = -hi - SUM_W'(1);
		if (v > hi) return {1'b0, {(COORD_W-1){1'b1}}};
		else if (v < lo) return {1'b1, {(COORD_W-1){1'b0}}};
		else return v[COORD_W-1:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(32767)) return 16'sh7fff;
		else if (v < -SUM_W'(32768)) return 16'sh8000;
		else return v[15:0];
	endfunction

endpackage

@@ sv/henon_map_point_generator.sv @@
// henon map point generator: microcoded sequencer around one shared multiplier
//
//  port group | dir | request fields
//  s_*        | in  | tdata[0] new_run
//  m_*        | out | tdata pixel_x, pixel_y, outside_count; tuser outside
//  apb        | cfg | coef_a, coef_b, screen_scale, screen_center, screen_limit
//
// an item runs through one accept step and seven microcode steps that share
// a single 33x33 signed multiplier over five products (x*x, a*sq, b*x, scale*x', scale*y')
// the result goes to an output register; the last step holds while it is full and not read
// reset clears the map point, the counter, the sequencer and loads the default registers
// s_tready is high only in the accept step
module henon_map_point_generator #(
	parameter int unsigned COORD_FRAC_BITS = hmpg_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] new_run, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] pixel_x, [31:16] pixel_y, [55:32] outside_count
	output logic        m_tuser,   // [0] outside
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hmpg_pkg::*;

	localparam int unsigned PIX_SHIFT = SCALE_FRAC_BITS + COORD_FRAC_BITS;

	logic signed [COORD_W-1:0] coef_a_q, coef_b_q;
	logic [SCALE_W-1:0]        scale_q;
	logic [PIX_W-1:0]          center_q, limit_q;

	logic signed [COORD_W-1:0] map_x_q, map_y_q, sq_q, nx_q;
	logic signed [PROD_W-1:0]  p_q;
	logic signed [15:0]        px_q;
	logic [COUNT_W-1:0]        count_q;
	logic [STEP_W-1:0]         step_q;
	logic                      m_tvalid_q;
	logic [55:0]               m_tdata_q;
	logic                      m_tuser_q;

	ctrl_t                     ctrl;
	logic                      in_fire, slot_free, out_fire, cfg_wr;
	logic [2:0]                reg_idx;
	logic signed [OPER_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0]  prod, p_sh, p_pix;
	logic signed [SUM_W-1:0]   nx_sum, pix_sum;
	logic                      pix_frac;
	logic signed [15:0]        py_w;
	logic                      outside_w;
	logic [COUNT_W-1:0]        count_next;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];

	always_comb begin
		case (reg_idx)
			REG_COEF_A:        prdata = coef_a_q;
			REG_COEF_B:        prdata = coef_b_q;
			REG_SCREEN_SCALE:  prdata = 32'(scale_q);
			REG_SCREEN_CENTER: prdata = 32'(center_q);
			REG_SCREEN_LIMIT:  prdata = 32'(limit_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= COEF_A_RST;
			coef_b_q <= COEF_B_RST;
			scale_q  <= SCREEN_SCALE_RST;
			center_q <= SCREEN_CENTER_RST;
			limit_q  <= SCREEN_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_COEF_A:        coef_a_q <= pwdata;
				REG_COEF_B:        coef_b_q <= pwdata;
				REG_SCREEN_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
				REG_SCREEN_CENTER: center_q <= pwdata[PIX_W-1:0];
				REG_SCREEN_LIMIT:  limit_q  <= pwdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	assign ctrl      = ucode(step_q);
	assign s_tready  = (ctrl.jmp == JMP_WAIT_IN);
	assign in_fire   = s_tvalid & s_tready;
	assign slot_free = ~m_tvalid_q | m_tready;
	assign out_fire  = ctrl.out_en & slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			case (ctrl.jmp)
				JMP_NEXT:     step_q <= ctrl.next;
				JMP_WAIT_IN:  if (in_fire) step_q <= ctrl.next;
				JMP_WAIT_OUT: if (slot_free) step_q <= ctrl.next;
				default:      step_q <= '0;
			endcase
		end
	end

	// shared multiplier
	always_comb begin
		case (ctrl.opa)
			OPA_X:     op_a = OPER_W'(map_x_q);
			OPA_A:     op_a = OPER_W'(coef_a_q);
			OPA_B:     op_a = OPER_W'(coef_b_q);
			OPA_SCALE: op_a = signed'({{(OPER_W-SCALE_W){1'b0}}, scale_q});
			default:   op_a = '0;
		endcase
		case (ctrl.opb)
			OPB_X:   op_b = OPER_W'(map_x_q);
			OPB_SQ:  op_b = OPER_W'(sq_q);
			OPB_NX:  op_b = OPER_W'(nx_q);
			OPB_Y:   op_b = OPER_W'(map_y_q);
			default: op_b = '0;
		endcase
	end

	assign prod = op_a * op_b;
	assign p_sh = p_q >>> COORD_FRAC_BITS;

	// x' = y + 1 - a*sq, exact before saturation
	assign nx_sum = SUM_W'(map_y_q) + (SUM_W'(1) << COORD_FRAC_BITS) - SUM_W'(p_sh);

	// pixel: floor then nudge negative sums with a fraction back toward zero
	assign p_pix    = p_q >>> PIX_SHIFT;
	assign pix_frac = |(p_q & ((PROD_W'(1) << PIX_SHIFT) - PROD_W'(1)));
	always_comb begin
		pix_sum = SUM_W'(p_pix) + SUM_W'({1'b0, center_q});
		if (pix_sum < 0 && pix_frac) pix_sum = pix_sum + SUM_W'(1);
	end
	assign py_w = sat16(pix_sum);

	assign outside_w = (px_q < 0) || (px_q > 16'(signed'({1'b0, limit_q}))) ||
		(py_w < 0) || (py_w > 16'(signed'({1'b0, limit_q})));
	assign count_next = (outside_w && count_q != COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;

	always_ff @(posedge clk) begin
		if (ctrl.p_en)  p_q  <= prod;
		if (ctrl.sq_en) sq_q <= sat32(SUM_W'(p_sh));
		if (ctrl.nx_en) nx_q <= sat32(nx_sum);
		if (ctrl.px_en) px_q <= py_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_x_q <= '0;
			map_y_q <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.map_en) begin
				map_x_q <= nx_q;
				map_y_q <= sat32(SUM_W'(p_sh));
			end
			if (in_fire && s_tdata[0]) count_q <= '0;
			else if (out_fire) count_q <= count_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			m_tdata_q <= {count_next, py_w, px_q};
			m_tuser_q <= outside_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> step_q == 3'd1)
		else $error("sequencer did not start after request accept");

	a_outside_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata[55:32] != '0)
		else $error("outside point with zero count");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && s_tdata[0]) |=> count_q >= $past(count_q))
		else $error("outside count dropped without a new run");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("pending result overwritten");

endmodule
